// File: sv/spk_pkg.sv
// ----------------------------------------------------------------------------
// spk_pkg
// shared widths, register map and configuration type of the shelf packer
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int LEN_W   = 20;   // lengths, widths and heights
	localparam int GAP_W   = 17;   // part gap
	localparam int OFS_W   = 21;   // signed bounding box offsets
	localparam int POS_W   = 23;   // signed placement coordinates
	localparam int IDX_W   = 6;    // sheet index on the result
	localparam int TAG_W   = 8;    // part and copy numbers
	localparam int ADDR_W  = 4;    // apb byte address
	localparam int DATA_W  = 32;   // apb data

	// register indexes on paddr[3:2]
	localparam logic [1:0] REG_SHEET_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SHEET_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PART_GAP     = 2'd2;

	localparam logic [LEN_W-1:0] SHEET_WIDTH_RST  = LEN_W'(120000);
	localparam logic [LEN_W-1:0] SHEET_HEIGHT_RST = LEN_W'(60000);
	localparam logic [GAP_W-1:0] PART_GAP_RST     = GAP_W'(500);

	typedef struct packed {
		logic [LEN_W-1:0] sheet_width;
		logic [LEN_W-1:0] sheet_height;
		logic [GAP_W-1:0] part_gap;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0] top;
		logic [LEN_W-1:0] height;
		logic [LEN_W-1:0] used_width;
	} shelf_t;

endpackage

// File: sv/spk_cfg.sv
// ----------------------------------------------------------------------------
// spk_cfg
// apb register file holding sheet size and part gap
// ----------------------------------------------------------------------------
module spk_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spk_pkg::ADDR_W-1:0] paddr,
	input  logic [spk_pkg::DATA_W-1:0] pwdata,
	output logic [spk_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output spk_pkg::cfg_t              cfg
);
	import spk_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sheet_width  <= SHEET_WIDTH_RST;
			cfg_q.sheet_height <= SHEET_HEIGHT_RST;
			cfg_q.part_gap     <= PART_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SHEET_WIDTH:  cfg_q.sheet_width  <= pwdata[LEN_W-1:0];
				REG_SHEET_HEIGHT: cfg_q.sheet_height <= pwdata[LEN_W-1:0];
				REG_PART_GAP:     cfg_q.part_gap     <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SHEET_WIDTH:  prdata = DATA_W'(cfg_q.sheet_width);
			REG_SHEET_HEIGHT: prdata = DATA_W'(cfg_q.sheet_height);
			REG_PART_GAP:     prdata = DATA_W'(cfg_q.part_gap);
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/shelf_packer_multi_sheet.sv
// ----------------------------------------------------------------------------
// shelf_packer_multi_sheet
// first-fit shelf packer over several sheets, state held in sheet and shelf rams
// a misfit item or an empty layout goes straight to a new sheet, else open sheets
// are searched one shelf per cycle through the shelf ram read port
// throughput: one transaction in flight; start is taken in the cycle done shows
// the result is held for exactly one cycle under done; the receiver cannot stall
// reset: open sheet count cleared, registers to defaults, ram contents left as is
// ----------------------------------------------------------------------------
module shelf_packer_multi_sheet #(
	parameter int MAX_SHEETS        = 8,
	parameter int SHELVES_PER_SHEET = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [spk_pkg::ADDR_W-1:0]        paddr,
	input  logic [spk_pkg::DATA_W-1:0]        pwdata,
	output logic [spk_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	// item command
	input  logic                              start,
	output logic                              busy,
	input  logic                              start_layout,
	input  logic [spk_pkg::LEN_W-1:0]         item_width,
	input  logic [spk_pkg::LEN_W-1:0]         item_height,
	input  logic                              item_fits,
	input  logic signed [spk_pkg::OFS_W-1:0]  box_min_x,
	input  logic signed [spk_pkg::OFS_W-1:0]  box_min_y,
	input  logic [spk_pkg::TAG_W-1:0]         part_index,
	input  logic [spk_pkg::TAG_W-1:0]         copy_number,
	// placement result
	output logic                              done,
	output logic                              status,
	output logic [spk_pkg::IDX_W-1:0]         sheet_index,
	output logic signed [spk_pkg::POS_W-1:0]  pos_x,
	output logic signed [spk_pkg::POS_W-1:0]  pos_y,
	output logic                              opened_sheet,
	output logic                              sheet_oversize,
	output logic [spk_pkg::TAG_W-1:0]         out_part_index,
	output logic [spk_pkg::TAG_W-1:0]         out_copy_number
);
	import spk_pkg::*;

	localparam int SLOTS = MAX_SHEETS * SHELVES_PER_SHEET;
	localparam int SW    = (MAX_SHEETS > 1) ? $clog2(MAX_SHEETS) : 1;
	localparam int CW    = $clog2(MAX_SHEETS + 1);
	localparam int NW    = $clog2(SHELVES_PER_SHEET + 1);
	localparam int KW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW    = 24;   // signed working width for length sums

	localparam logic [KW-1:0] SPS_K  = KW'(SHELVES_PER_SHEET);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_SHEETS);
	localparam logic [NW-1:0] SPS_N  = NW'(SHELVES_PER_SHEET);

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SHEET     = 6'b000010,   // sheet ram address settles
		ST_SHEET_CHK = 6'b000100,   // sheet entry on the read port
		ST_SCAN      = 6'b001000,   // shelves read and tested one a cycle
		ST_NEWSHELF  = 6'b010000,   // try a new shelf above the last one
		ST_NEW       = 6'b100000    // open a new sheet or give up
	} state_t;

	cfg_t cfg;

	spk_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// control state
	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   s_q;
	logic [NW-1:0]   r_q;
	logic [NW-1:0]   n_q;
	logic            iss_s1;
	logic [NW-1:0]   r_s1;
	logic            done_q;

	// transaction held for the whole search
	logic [LEN_W-1:0]        w_q;
	logic [LEN_W-1:0]        h_q;
	logic                    fits_q;
	logic signed [OFS_W-1:0] minx_q;
	logic signed [OFS_W-1:0] miny_q;
	logic [TAG_W-1:0]        pidx_q;
	logic [TAG_W-1:0]        copy_q;

	// result registers
	logic                    status_q;
	logic [IDX_W-1:0]        sheet_index_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic                    opened_q;
	logic                    over_q;
	logic [TAG_W-1:0]        out_pidx_q;
	logic [TAG_W-1:0]        out_copy_q;

	// sheet ram, one entry per sheet, read at s_q every cycle
	logic [LEN_W-1:0] sheet_used_mem [MAX_SHEETS];
	logic [NW-1:0]    sheet_cnt_mem  [MAX_SHEETS];
	logic             sheet_over_mem [MAX_SHEETS];
	logic [LEN_W-1:0] sheet_used_rd_q;
	logic [NW-1:0]    sheet_cnt_rd_q;
	logic             sheet_over_rd_q;
	logic             sheet_we;
	logic [SW-1:0]    sheet_wa;
	logic [LEN_W-1:0] sheet_wused;
	logic [NW-1:0]    sheet_wcnt;
	logic             sheet_wover;

	// shelf ram, SHELVES_PER_SHEET entries per sheet
	shelf_t        shelf_mem [SLOTS];
	shelf_t        shelf_rd_q;
	logic          shelf_we;
	logic [KW-1:0] shelf_wa;
	shelf_t        shelf_wd;
	logic [KW-1:0] shelf_ra;
	logic [KW-1:0] base;

	// arithmetic
	logic signed [AW-1:0] gap_a, uw_a, uh_a, w_a, h_a;
	logic signed [AW-1:0] used_a, need_a, sx_hit_a, y_a, ysum_a;
	logic signed [AW-1:0] minx_a, miny_a, px_a, py_a;
	logic                 used_nz, hit, last_miss, issue, newshelf_ok, last_sheet, full;
	logic [CW-1:0]        count_start;

	// finishing signals
	logic                 fin, fin_unplaced, fin_opened;
	logic [SW-1:0]        fin_sheet;
	logic signed [AW-1:0] fin_sx, fin_sy;

	assign gap_a = signed'(AW'(cfg.part_gap));
	assign uw_a  = signed'(AW'(cfg.sheet_width)) - (gap_a <<< 1);
	assign uh_a  = signed'(AW'(cfg.sheet_height)) - (gap_a <<< 1);
	assign w_a   = signed'(AW'(w_q));
	assign h_a   = signed'(AW'(h_q));

	assign base     = KW'(s_q) * SPS_K;
	assign issue    = (state_q == ST_SCAN) && (r_q < n_q) && !hit;
	assign shelf_ra = base + KW'(r_q);

	// shelf test on the entry returned by the read port
	assign used_a   = signed'(AW'(shelf_rd_q.used_width));
	assign used_nz  = (shelf_rd_q.used_width != '0);
	assign need_a   = used_nz ? (used_a + gap_a + w_a) : w_a;
	assign sx_hit_a = used_nz ? (used_a + gap_a) : '0;
	assign hit      = iss_s1 && (h_q <= shelf_rd_q.height) && (need_a <= uw_a);
	assign last_miss = iss_s1 && !hit && (r_s1 == n_q - NW'(1));

	// new shelf above the last one of this sheet
	assign y_a         = (sheet_cnt_rd_q != '0) ?
	                     (signed'(AW'(sheet_used_rd_q)) + gap_a) : '0;
	assign ysum_a      = y_a + h_a;
	assign newshelf_ok = (sheet_cnt_rd_q < SPS_N) && (ysum_a <= uh_a);

	assign last_sheet  = ((CW'(s_q) + CW'(1)) == count_q);
	assign full        = (count_q >= MAX_C);
	assign count_start = start_layout ? '0 : count_q;

	// what the current state writes and reports
	always_comb begin
		fin          = 1'b0;
		fin_unplaced = 1'b0;
		fin_opened   = 1'b0;
		fin_sheet    = s_q;
		fin_sx       = '0;
		fin_sy       = '0;
		shelf_we     = 1'b0;
		shelf_wa     = base + KW'(r_s1);
		shelf_wd     = '{top: shelf_rd_q.top, height: shelf_rd_q.height,
		                 used_width: need_a[LEN_W-1:0]};
		sheet_we     = 1'b0;
		sheet_wa     = s_q;
		sheet_wused  = ysum_a[LEN_W-1:0];
		sheet_wcnt   = sheet_cnt_rd_q + NW'(1);
		sheet_wover  = sheet_over_rd_q;
		unique case (state_q)
			ST_SCAN: begin
				if (hit) begin
					fin      = 1'b1;
					fin_sx   = sx_hit_a;
					fin_sy   = signed'(AW'(shelf_rd_q.top));
					shelf_we = 1'b1;
				end
			end
			ST_NEWSHELF: begin
				if (newshelf_ok) begin
					fin      = 1'b1;
					fin_sy   = y_a;
					shelf_we = 1'b1;
					shelf_wa = base + KW'(sheet_cnt_rd_q);
					shelf_wd = '{top: y_a[LEN_W-1:0], height: h_q, used_width: w_q};
					sheet_we = 1'b1;
				end
			end
			ST_NEW: begin
				fin = 1'b1;
				if (full) begin
					fin_unplaced = 1'b1;
				end else begin
					fin_opened  = 1'b1;
					fin_sheet   = count_q[SW-1:0];
					shelf_we    = 1'b1;
					shelf_wa    = KW'(count_q[SW-1:0]) * SPS_K;
					shelf_wd    = '{top: '0, height: h_q, used_width: w_q};
					sheet_we    = 1'b1;
					sheet_wa    = count_q[SW-1:0];
					sheet_wused = h_q;
					sheet_wcnt  = NW'(1);
					sheet_wover = !fits_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			s_q     <= '0;
			r_q     <= '0;
			n_q     <= '0;
			iss_s1  <= 1'b0;
			r_s1    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			iss_s1 <= issue;
			r_s1   <= r_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						count_q <= count_start;
						s_q     <= '0;
						state_q <= (item_fits && count_start != '0) ? ST_SHEET : ST_NEW;
					end
				end
				ST_SHEET: begin
					state_q <= ST_SHEET_CHK;
				end
				ST_SHEET_CHK: begin
					// oversize sheets never take further parts
					if (sheet_over_rd_q) begin
						if (last_sheet) begin
							state_q <= ST_NEW;
						end else begin
							s_q     <= s_q + SW'(1);
							state_q <= ST_SHEET;
						end
					end else begin
						n_q     <= sheet_cnt_rd_q;
						r_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						r_q <= r_q + NW'(1);
					end
					if (hit) begin
						state_q <= ST_IDLE;
					end else if (last_miss) begin
						state_q <= ST_NEWSHELF;
					end
				end
				ST_NEWSHELF: begin
					if (newshelf_ok) begin
						state_q <= ST_IDLE;
					end else if (last_sheet) begin
						state_q <= ST_NEW;
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= ST_SHEET;
					end
				end
				ST_NEW: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			w_q    <= item_width;
			h_q    <= item_height;
			fits_q <= item_fits;
			minx_q <= box_min_x;
			miny_q <= box_min_y;
			pidx_q <= part_index;
			copy_q <= copy_number;
		end
	end

	// sheet ram
	always_ff @(posedge clk) begin
		if (sheet_we) begin
			sheet_used_mem[sheet_wa] <= sheet_wused;
			sheet_cnt_mem[sheet_wa]  <= sheet_wcnt;
			sheet_over_mem[sheet_wa] <= sheet_wover;
		end
		sheet_used_rd_q <= sheet_used_mem[s_q];
		sheet_cnt_rd_q  <= sheet_cnt_mem[s_q];
		sheet_over_rd_q <= sheet_over_mem[s_q];
	end

	// shelf ram, a hit ends the scan so a write never meets a pending read
	always_ff @(posedge clk) begin
		if (shelf_we) begin
			shelf_mem[shelf_wa] <= shelf_wd;
		end
		shelf_rd_q <= shelf_mem[shelf_ra];
	end

	// placement position: gap plus shelf corner minus box minimum
	assign minx_a = AW'(minx_q);
	assign miny_a = AW'(miny_q);
	assign px_a   = gap_a + fin_sx - minx_a;
	assign py_a   = gap_a + fin_sy - miny_a;

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q      <= fin_unplaced;
			sheet_index_q <= fin_unplaced ? '0 : IDX_W'(fin_sheet);
			pos_x_q       <= fin_unplaced ? '0 : px_a[POS_W-1:0];
			pos_y_q       <= fin_unplaced ? '0 : py_a[POS_W-1:0];
			opened_q      <= fin_opened;
			over_q        <= fin_opened & !fits_q;
			out_pidx_q    <= pidx_q;
			out_copy_q    <= copy_q;
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign sheet_index     = sheet_index_q;
	assign pos_x           = pos_x_q;
	assign pos_y           = pos_y_q;
	assign opened_sheet    = opened_q;
	assign sheet_oversize  = over_q;
	assign out_part_index  = out_pidx_q;
	assign out_copy_number = out_copy_q;

endmodule
